// ----- sv/frce_pkg.sv -----
// Shared types, codes and helpers for the framebuffer row command engine.
// Depends on nothing; every other file of the block refers to it by scoped names.
`default_nettype none

package frce_pkg;

	localparam int unsigned DIV_STEPS = 16;
	localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

	typedef logic [2:0] action_t;
	localparam action_t ACT_CLEAR  = 3'd0;
	localparam action_t ACT_SCROLL = 3'd1;
	localparam action_t ACT_FILL   = 3'd2;
	localparam action_t ACT_BITMAP = 3'd3;
	localparam action_t ACT_NEXT   = 3'd4;

	typedef logic [1:0] kind_t;
	localparam kind_t KIND_NONE   = 2'd0;
	localparam kind_t KIND_FILL   = 2'd1;
	localparam kind_t KIND_FRAME  = 2'd2;
	localparam kind_t KIND_MEMORY = 2'd3;

	typedef logic [1:0] cfg_index_t;
	localparam cfg_index_t CFG_FRAME_WIDTH  = 2'd0;
	localparam cfg_index_t CFG_FRAME_HEIGHT = 2'd1;
	localparam cfg_index_t CFG_ROW_PITCH    = 2'd2;
	localparam cfg_index_t CFG_PIXEL_BITS   = 2'd3;

	localparam logic [15:0] RST_FRAME_WIDTH  = 16'd640;
	localparam logic [15:0] RST_FRAME_HEIGHT = 16'd480;
	localparam logic [15:0] RST_ROW_PITCH    = 16'd640;
	localparam logic [5:0]  RST_PIXEL_BITS   = 6'd8;

	localparam logic [5:0] PIXEL_BITS_8  = 6'd8;
	localparam logic [5:0] PIXEL_BITS_16 = 6'd16;

	typedef struct packed {
		action_t     action;
		logic [15:0] x;
		logic [15:0] y;
		logic [15:0] area_width;
		logic [15:0] area_height;
		logic [31:0] color;
		logic [15:0] scroll_lines;
		logic [31:0] source_address;
	} cmd_t;

	typedef struct packed {
		kind_t       op_kind;
		logic [31:0] dest_offset;
		logic [31:0] source_offset;
		logic [17:0] unit_count;
		logic [2:0]  unit_bytes;
		logic [31:0] fill_value;
		logic        last;
	} row_t;

	typedef struct packed {
		logic [15:0] frame_width;
		logic [15:0] frame_height;
		logic [15:0] row_pitch;
		logic [5:0]  pixel_bits;
	} cfg_t;

	typedef struct packed {
		logic capture;
		logic div_step;
		logic start_apply;
		logic row_write;
	} dp_ctrl_t;

	typedef struct packed {
		action_t action;
		logic    div_last;
		logic    out_free;
	} dp_status_t;

	// Bytes per pixel, saturating at four.
	function automatic logic [2:0] pixel_bytes(input logic [5:0] bits);
		logic [2:0] b;
		b = bits[5:3];
		return (b > 3'd4) ? 3'd4 : b;
	endfunction

endpackage

`default_nettype wire

// ----- sv/frce_cmd_if.sv -----
// Command channel of the framebuffer row command engine.
// Depends on frce_pkg for the payload type.
`default_nettype none

interface frce_cmd_if;
	logic           valid;
	logic           ready;
	frce_pkg::cmd_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- sv/frce_row_if.sv -----
// Row descriptor channel of the framebuffer row command engine.
// Depends on frce_pkg for the payload type.
`default_nettype none

interface frce_row_if;
	logic           valid;
	logic           ready;
	frce_pkg::row_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- sv/frce_ctrl.sv -----
// Sequencing state machine of the framebuffer row command engine.
// Depends on frce_pkg; drives the datapath through dp_ctrl_t and reads dp_status_t.
`default_nettype none

module frce_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cmd_valid,
	input  wire frce_pkg::action_t    cmd_action,
	output logic                      cmd_ready,
	input  wire frce_pkg::dp_status_t status,
	output frce_pkg::dp_ctrl_t        ctrl
);

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_MUL   = 5'b00010,
		S_DIV   = 5'b00100,
		S_START = 5'b01000,
		S_ROW   = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   accept;

	assign cmd_ready = (state_q == S_IDLE);
	assign accept    = cmd_valid && cmd_ready;

	always_comb begin
		state_d          = state_q;
		ctrl             = '0;
		ctrl.capture     = accept;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (cmd_action)
						frce_pkg::ACT_CLEAR, frce_pkg::ACT_SCROLL: state_d = S_DIV;
						frce_pkg::ACT_FILL, frce_pkg::ACT_BITMAP,
						frce_pkg::ACT_NEXT: state_d = S_MUL;
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_MUL: begin
				state_d = (status.action == frce_pkg::ACT_NEXT) ? S_ROW : S_START;
			end
			S_DIV: begin
				ctrl.div_step = 1'b1;
				if (status.div_last) begin
					state_d = S_START;
				end
			end
			S_START: begin
				ctrl.start_apply = 1'b1;
				state_d          = S_IDLE;
			end
			S_ROW: begin
				if (status.out_free) begin
					ctrl.row_write = 1'b1;
					state_d        = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

// ----- sv/frce_dp.sv -----
// Datapath of the framebuffer row command engine: command capture, row pitch
// multiplier, scroll remainder divider, transfer state and output register. Depends on frce_pkg.
`default_nettype none

module frce_dp (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire frce_pkg::cfg_t     cfg,
	input  wire frce_pkg::cmd_t     cmd_data,
	input  wire frce_pkg::dp_ctrl_t ctrl,
	output frce_pkg::dp_status_t    status,
	input  wire logic               row_ready,
	output logic                    row_valid,
	output frce_pkg::row_t          row_data
);

	frce_pkg::cmd_t cmd_q;

	// Multiplier: one 16 x 16 product a cycle, registered.
	logic [15:0] mul_a;
	logic [31:0] prod_q;

	// Restoring divider for scroll_lines mod frame_height.
	logic [15:0]                    dvd_q;
	logic [15:0]                    rem_q;
	logic [frce_pkg::DIV_CNT_W-1:0] cnt_q;
	logic [16:0]                    rem_shift;
	logic [16:0]                    div_den;

	// Transfer state.
	frce_pkg::kind_t active_q;
	logic [15:0]     rows_q;
	logic [31:0]     dest_q;
	logic [31:0]     src_ptr_q;
	logic [15:0]     src_row_q;
	logic [17:0]     units_q;
	logic [2:0]      unit_bytes_q;
	logic [31:0]     fill_word_q;
	logic [17:0]     stride_q;

	logic           row_valid_q;
	frce_pkg::row_t row_q;
	frce_pkg::row_t row_d;

	logic [2:0]  bpb;
	logic [17:0] x_bytes;
	logic [17:0] w_bytes;
	logic [31:0] start_dest;
	logic        fill_ok;
	logic [15:0] w_room;
	logic [15:0] h_room;
	logic [15:0] clip_w;
	logic [15:0] clip_h;
	logic [16:0] src_row_inc;
	logic        row_idle;

	assign mul_a = (cmd_q.action == frce_pkg::ACT_NEXT) ? src_row_q : cmd_q.y;

	always_ff @(posedge clk) begin
		if (ctrl.capture) begin
			cmd_q <= cmd_data;
		end
		prod_q <= {16'd0, mul_a} * {16'd0, cfg.row_pitch};
	end

	assign div_den   = {1'b0, cfg.frame_height};
	assign rem_shift = {rem_q, dvd_q[15]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctrl.capture) begin
			cnt_q <= '0;
		end else if (ctrl.div_step) begin
			cnt_q <= cnt_q + frce_pkg::DIV_CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.capture) begin
			dvd_q <= cmd_data.scroll_lines;
			rem_q <= '0;
		end else if (ctrl.div_step) begin
			dvd_q <= {dvd_q[14:0], 1'b0};
			rem_q <= (rem_shift >= div_den) ? 16'(rem_shift - div_den) : rem_shift[15:0];
		end
	end

	assign status.action   = cmd_q.action;
	assign status.div_last = (cnt_q == frce_pkg::DIV_CNT_W'(frce_pkg::DIV_STEPS - 1));
	assign status.out_free = !row_valid_q || row_ready;

	// Start command arithmetic.
	assign bpb        = frce_pkg::pixel_bytes(cfg.pixel_bits);
	assign x_bytes    = {2'b00, cmd_q.x} * {15'd0, bpb};
	assign w_bytes    = {2'b00, cmd_q.area_width} * {15'd0, bpb};
	assign start_dest = {14'd0, x_bytes} + prod_q;
	assign fill_ok    = (cmd_q.x < cfg.frame_width) && (cmd_q.y < cfg.frame_height);
	assign w_room     = cfg.frame_width - cmd_q.x;
	assign h_room     = cfg.frame_height - cmd_q.y;
	assign clip_w     = (cmd_q.area_width > w_room) ? w_room : cmd_q.area_width;
	assign clip_h     = (cmd_q.area_height > h_room) ? h_room : cmd_q.area_height;

	assign src_row_inc = {1'b0, src_row_q} + 17'd1;
	assign row_idle    = (active_q == frce_pkg::KIND_NONE) || (rows_q == 16'd0);

	always_comb begin
		row_d = '0;
		if (row_idle) begin
			row_d.unit_bytes = 3'd1;
			row_d.last       = 1'b1;
		end else begin
			row_d.op_kind     = active_q;
			row_d.dest_offset = dest_q;
			unique case (active_q)
				frce_pkg::KIND_FRAME:  row_d.source_offset = prod_q;
				frce_pkg::KIND_MEMORY: row_d.source_offset = src_ptr_q;
				default:               row_d.source_offset = 32'd0;
			endcase
			row_d.unit_count = units_q;
			row_d.unit_bytes = unit_bytes_q;
			row_d.fill_value = fill_word_q;
			row_d.last       = (rows_q == 16'd1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q     <= frce_pkg::KIND_NONE;
			rows_q       <= '0;
			dest_q       <= '0;
			src_ptr_q    <= '0;
			src_row_q    <= '0;
			units_q      <= '0;
			unit_bytes_q <= 3'd1;
			fill_word_q  <= '0;
			stride_q     <= '0;
		end else if (ctrl.start_apply) begin
			unique case (cmd_q.action)
				frce_pkg::ACT_CLEAR, frce_pkg::ACT_SCROLL: begin
					dest_q       <= '0;
					src_ptr_q    <= '0;
					stride_q     <= '0;
					units_q      <= {2'b00, cfg.row_pitch};
					unit_bytes_q <= 3'd1;
					fill_word_q  <= '0;
					src_row_q    <= (cfg.frame_height != 16'd0) ? rem_q : 16'd0;
					rows_q       <= cfg.frame_height;
					if (cfg.frame_height == 16'd0) begin
						active_q <= frce_pkg::KIND_NONE;
					end else if (cmd_q.action == frce_pkg::ACT_CLEAR) begin
						active_q <= frce_pkg::KIND_FILL;
					end else begin
						active_q <= frce_pkg::KIND_FRAME;
					end
				end
				frce_pkg::ACT_FILL: begin
					if (!fill_ok) begin
						active_q <= frce_pkg::KIND_NONE;
						rows_q   <= '0;
					end else begin
						if (cfg.pixel_bits == frce_pkg::PIXEL_BITS_8) begin
							unit_bytes_q <= 3'd1;
							fill_word_q  <= {24'd0, cmd_q.color[7:0]};
						end else if (cfg.pixel_bits == frce_pkg::PIXEL_BITS_16) begin
							unit_bytes_q <= 3'd2;
							fill_word_q  <= {16'd0, cmd_q.color[15:0]};
						end else begin
							unit_bytes_q <= 3'd4;
							fill_word_q  <= cmd_q.color;
						end
						units_q   <= {2'b00, clip_w};
						dest_q    <= start_dest;
						src_ptr_q <= '0;
						stride_q  <= '0;
						src_row_q <= '0;
						rows_q    <= clip_h;
						active_q  <= (clip_h != 16'd0) ? frce_pkg::KIND_FILL
							: frce_pkg::KIND_NONE;
					end
				end
				frce_pkg::ACT_BITMAP: begin
					units_q      <= w_bytes;
					stride_q     <= w_bytes;
					unit_bytes_q <= 3'd1;
					fill_word_q  <= '0;
					dest_q       <= start_dest;
					src_ptr_q    <= cmd_q.source_address;
					src_row_q    <= '0;
					rows_q       <= cmd_q.area_height;
					active_q     <= (cmd_q.area_height != 16'd0) ? frce_pkg::KIND_MEMORY
						: frce_pkg::KIND_NONE;
				end
				default: begin
					active_q <= active_q;
				end
			endcase
		end else if (ctrl.row_write && !row_idle) begin
			rows_q    <= rows_q - 16'd1;
			dest_q    <= dest_q + {16'd0, cfg.row_pitch};
			src_ptr_q <= src_ptr_q + {14'd0, stride_q};
			if (active_q == frce_pkg::KIND_FRAME) begin
				src_row_q <= (src_row_inc >= div_den) ? 16'd0 : src_row_inc[15:0];
			end
			if (rows_q == 16'd1) begin
				active_q <= frce_pkg::KIND_NONE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= 1'b0;
		end else if (ctrl.row_write) begin
			row_valid_q <= 1'b1;
		end else if (row_ready) begin
			row_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.row_write) begin
			row_q <= row_d;
		end
	end

	assign row_valid = row_valid_q;
	assign row_data  = row_q;

endmodule

`default_nettype wire

// ----- sv/framebuffer_row_command_engine.sv -----
// Top level of the framebuffer row command engine: configuration registers and
// the join of frce_ctrl and frce_dp. Depends on frce_pkg, frce_cmd_if and frce_row_if.
`default_nettype none

// Channel     Direction  Beat carries
// ----------  ---------  --------------------------------------------------------
// cmd         in         one command: clear, scroll, fill, bitmap or next-row
// row         out        one row descriptor, given for every next-row command
// cfg_*       in         one register write (frame size, row pitch, pixel bits)
//
// A next-row command passes the registered row pitch multiplier, then waits in the
// row state until the output register is free and registers its descriptor; fill
// and bitmap starts pass the multiplier and then apply. Clear and scroll wait on
// the bit-serial divider that reduces the scroll distance modulo the frame height
// and then apply. Commands with unused codes are taken and have no effect.
// Reset gives the register defaults of a 640 by 480 byte-per-pixel frame and no
// active transfer. A descriptor waits in its output register while row is
// stalled; the engine takes further start commands meanwhile, and a next-row
// command then holds until the waiting descriptor has gone.

module framebuffer_row_command_engine (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire frce_pkg::cfg_index_t cfg_index,
	input  wire logic [15:0]          cfg_data,
	frce_cmd_if.sink                  cmd,
	frce_row_if.source                row
);

	frce_pkg::cfg_t       cfg_q;
	frce_pkg::dp_ctrl_t   dp_ctrl;
	frce_pkg::dp_status_t dp_status;

	// Configuration registers. The user must write them only while the engine is
	// quiet; the block does not enforce it. The datapath reads them with no shadow copy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_width  <= frce_pkg::RST_FRAME_WIDTH;
			cfg_q.frame_height <= frce_pkg::RST_FRAME_HEIGHT;
			cfg_q.row_pitch    <= frce_pkg::RST_ROW_PITCH;
			cfg_q.pixel_bits   <= frce_pkg::RST_PIXEL_BITS;
		end else if (cfg_we) begin
			unique case (cfg_index)
				frce_pkg::CFG_FRAME_WIDTH:  cfg_q.frame_width  <= cfg_data;
				frce_pkg::CFG_FRAME_HEIGHT: cfg_q.frame_height <= cfg_data;
				frce_pkg::CFG_ROW_PITCH:    cfg_q.row_pitch    <= cfg_data;
				frce_pkg::CFG_PIXEL_BITS:   cfg_q.pixel_bits   <= cfg_data[5:0];
				default:                    cfg_q              <= cfg_q;
			endcase
		end
	end

	// The controller sequences each command; it owns the command ready.
	frce_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd.valid),
		.cmd_action (cmd.data.action),
		.cmd_ready  (cmd.ready),
		.status     (dp_status),
		.ctrl       (dp_ctrl)
	);

	// The datapath holds the transfer state and the output register.
	frce_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd_data  (cmd.data),
		.ctrl      (dp_ctrl),
		.status    (dp_status),
		.row_ready (row.ready),
		.row_valid (row.valid),
		.row_data  (row.data)
	);

endmodule

`default_nettype wire

// ----- dv/framebuffer_row_command_engine_test.sv -----
// Self-checking testbench for the framebuffer row command engine: a directed table,
// then random command sequences over several frame settings and idling patterns.
// Depends on frce_pkg, frce_cmd_if, frce_row_if and the engine's top level.
`default_nettype none

module framebuffer_row_command_engine_test;
	timeunit 1ns;
	timeprecision 1ps;

	// Action codes that the engine takes and then ignores.
	localparam frce_pkg::action_t ACT_SPARE_A = 3'd5;
	localparam frce_pkg::action_t ACT_SPARE_B = 3'd6;
	localparam frce_pkg::action_t ACT_SPARE_C = 3'd7;

	localparam int NUM_DIRECTED    = 26;
	localparam int ITEMS_PER_PHASE = 212;
	// Clear and scroll starts give no descriptor, so the engine may still be busy with
	// one in its divider once the last descriptor has come; the settle time covers it.
	localparam int SETTLE_CYCLES   = 32;
	localparam int WATCHDOG_LIMIT  = 2000;

	typedef struct {
		frce_pkg::cmd_t c;
		bit             typed;
		frce_pkg::row_t want;
	} directed_step_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	frce_pkg::cfg_index_t cfg_index;
	logic [15:0]          cfg_data;

	frce_cmd_if cmd_ch ();
	frce_row_if row_ch ();

	framebuffer_row_command_engine dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd_ch),
		.row       (row_ch)
	);

	// The testbench's own copy of the registers as the engine should hold them.
	logic [15:0] fb_width;
	logic [15:0] fb_height;
	logic [15:0] fb_pitch;
	logic [5:0]  fb_pixel_bits;

	// The transfer in progress, as the engine should track it.
	frce_pkg::kind_t cur_kind;
	logic [15:0]     rows_remaining;
	logic [31:0]     dst_ptr;
	logic [31:0]     src_ptr;
	logic [15:0]     src_row;
	logic [17:0]     units_per_row;
	logic [2:0]      unit_size;
	logic [31:0]     fill_pattern;
	logic [17:0]     src_step;

	// Row descriptors that next-row beats have asked for and that have not yet come.
	frce_pkg::row_t pending_rows[$];

	int error_count;
	int items_sent;
	int commands_taken;
	int rows_checked;
	int idle_rows_checked;
	int settings_used;
	int quiet_cycles;
	int send_idle_pct;
	int recv_stall_pct;

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	function automatic logic [2:0] bytes_per_pixel();
		logic [2:0] b;
		b = fb_pixel_bits[5:3];
		return (b > 3'd4) ? 3'd4 : b;
	endfunction

	function automatic void begin_transfer(input frce_pkg::kind_t k, input logic [15:0] rows);
		cur_kind = (rows != 16'd0) ? k : frce_pkg::KIND_NONE;
		rows_remaining = rows;
	endfunction

	function automatic frce_pkg::cmd_t make_cmd(input frce_pkg::action_t a,
			input logic [15:0] x, input logic [15:0] y, input logic [15:0] w,
			input logic [15:0] h, input logic [31:0] color, input logic [15:0] lines,
			input logic [31:0] addr);
		frce_pkg::cmd_t c;
		c.action = a;
		c.x = x;
		c.y = y;
		c.area_width = w;
		c.area_height = h;
		c.color = color;
		c.scroll_lines = lines;
		c.source_address = addr;
		return c;
	endfunction

	function automatic frce_pkg::row_t make_row(input frce_pkg::kind_t k,
			input logic [31:0] dest, input logic [31:0] src, input logic [17:0] units,
			input logic [2:0] ubytes, input logic [31:0] fill, input logic last);
		frce_pkg::row_t r;
		r.op_kind = k;
		r.dest_offset = dest;
		r.source_offset = src;
		r.unit_count = units;
		r.unit_bytes = ubytes;
		r.fill_value = fill;
		r.last = last;
		return r;
	endfunction

	// Applies one accepted command to the tracked transfer. A next-row command
	// yields the descriptor that the engine must give for it.
	task automatic predict_command(input frce_pkg::cmd_t c, output bit has_row,
			output frce_pkg::row_t r);
		logic [2:0]  bpb;
		logic [15:0] w16;
		logic [15:0] h16;
		bpb = bytes_per_pixel();
		has_row = 1'b0;
		r = '0;
		case (c.action)
			frce_pkg::ACT_CLEAR, frce_pkg::ACT_SCROLL: begin
				// Both walk every row of the frame from offset zero; scroll also
				// starts its source row at the distance reduced by the height.
				dst_ptr = '0;
				src_ptr = '0;
				src_step = '0;
				units_per_row = 18'(fb_pitch);
				unit_size = 3'd1;
				fill_pattern = '0;
				src_row = (fb_height != 16'd0) ? (c.scroll_lines % fb_height) : 16'd0;
				begin_transfer((c.action == frce_pkg::ACT_CLEAR) ? frce_pkg::KIND_FILL
					: frce_pkg::KIND_FRAME, fb_height);
			end
			frce_pkg::ACT_FILL: begin
				if (c.x >= fb_width || c.y >= fb_height) begin
					// An origin off the frame cancels whatever was running.
					cur_kind = frce_pkg::KIND_NONE;
					rows_remaining = '0;
				end else begin
					w16 = c.area_width;
					h16 = c.area_height;
					if (32'(w16) > 32'(fb_width) - 32'(c.x))
						w16 = fb_width - c.x;
					if (32'(h16) > 32'(fb_height) - 32'(c.y))
						h16 = fb_height - c.y;
					if (fb_pixel_bits == frce_pkg::PIXEL_BITS_8) begin
						unit_size = 3'd1;
						fill_pattern = {24'd0, c.color[7:0]};
					end else if (fb_pixel_bits == frce_pkg::PIXEL_BITS_16) begin
						unit_size = 3'd2;
						fill_pattern = {16'd0, c.color[15:0]};
					end else begin
						unit_size = 3'd4;
						fill_pattern = c.color;
					end
					units_per_row = 18'(w16);
					dst_ptr = 32'(c.x) * 32'(bpb) + 32'(c.y) * 32'(fb_pitch);
					src_ptr = '0;
					src_step = '0;
					src_row = '0;
					begin_transfer(frce_pkg::KIND_FILL, h16);
				end
			end
			frce_pkg::ACT_BITMAP: begin
				// No clipping here: the bitmap may run past the frame edges.
				units_per_row = 18'(32'(c.area_width) * 32'(bpb));
				src_step = units_per_row;
				unit_size = 3'd1;
				fill_pattern = '0;
				dst_ptr = 32'(c.x) * 32'(bpb) + 32'(c.y) * 32'(fb_pitch);
				src_ptr = c.source_address;
				src_row = '0;
				begin_transfer(frce_pkg::KIND_MEMORY, c.area_height);
			end
			frce_pkg::ACT_NEXT: begin
				has_row = 1'b1;
				if (cur_kind == frce_pkg::KIND_NONE || rows_remaining == 16'd0) begin
					r = make_row(frce_pkg::KIND_NONE, '0, '0, '0, 3'd1, '0, 1'b1);
				end else begin
					r.op_kind = cur_kind;
					r.dest_offset = dst_ptr;
					if (cur_kind == frce_pkg::KIND_FRAME)
						r.source_offset = 32'(src_row) * 32'(fb_pitch);
					else if (cur_kind == frce_pkg::KIND_MEMORY)
						r.source_offset = src_ptr;
					else
						r.source_offset = '0;
					r.unit_count = units_per_row;
					r.unit_bytes = unit_size;
					r.fill_value = fill_pattern;
					r.last = (rows_remaining == 16'd1);
					// Advancing uses the registers as they are now, so a height
					// lowered under a running scroll folds the source row to zero.
					rows_remaining = rows_remaining - 16'd1;
					dst_ptr = dst_ptr + 32'(fb_pitch);
					src_ptr = src_ptr + 32'(src_step);
					if (cur_kind == frce_pkg::KIND_FRAME) begin
						if (32'(src_row) + 32'd1 >= 32'(fb_height))
							src_row = '0;
						else
							src_row = src_row + 16'd1;
					end
					if (rows_remaining == 16'd0)
						cur_kind = frce_pkg::KIND_NONE;
				end
			end
			default: begin
				// Spare action codes leave everything as it was.
			end
		endcase
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("MISMATCH %s: got 0x%08h, want 0x%08h (descriptor %0d)",
			what, got, want, rows_checked);
		error_count++;
	endtask

	task automatic check_field(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			report_mismatch(what, got, want);
	endtask

	task automatic check_row(input frce_pkg::row_t got);
		frce_pkg::row_t want;
		if (pending_rows.size() == 0) begin
			report_mismatch("descriptor beat with none outstanding", got.dest_offset, '0);
		end else begin
			want = pending_rows.pop_front();
			check_field("op_kind", 32'(got.op_kind), 32'(want.op_kind));
			check_field("dest_offset", got.dest_offset, want.dest_offset);
			check_field("source_offset", got.source_offset, want.source_offset);
			check_field("unit_count", 32'(got.unit_count), 32'(want.unit_count));
			check_field("unit_bytes", 32'(got.unit_bytes), 32'(want.unit_bytes));
			check_field("fill_value", got.fill_value, want.fill_value);
			check_field("last", 32'(got.last), 32'(want.last));
			if (want.op_kind == frce_pkg::KIND_NONE)
				idle_rows_checked++;
		end
		rows_checked++;
	endtask

	// Descriptors are taken at the rising edge; the receiver's ready is redrawn at
	// every falling edge from the stall rate of the current phase.
	always @(posedge clk) begin
		if (arst_n && row_ch.valid && row_ch.ready)
			check_row(row_ch.data);
	end

	always @(negedge clk) begin
		row_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	// The watchdog only counts cycles in which neither channel moves a beat.
	always @(posedge clk) begin
		if (!arst_n || (cmd_ch.valid && cmd_ch.ready) || (row_ch.valid && row_ch.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Watchdog: no beat on either channel for %0d cycles", quiet_cycles);
			$display("framebuffer_row_command_engine_test failed");
			$finish;
		end
	end

	// Offers one command, with idle cycles first at the phase's rate, and predicts
	// it at the edge where it is taken. Returns at the falling edge after that,
	// with valid still high so that back-to-back commands need no gap.
	task automatic push_command(input frce_pkg::cmd_t c, input bit typed,
			input frce_pkg::row_t want);
		bit             has_row;
		frce_pkg::row_t predicted;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			cmd_ch.valid <= 1'b0;
			@(negedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.data <= c;
		do
			@(posedge clk);
		while (!cmd_ch.ready);
		predict_command(c, has_row, predicted);
		if (has_row)
			pending_rows.push_back(typed ? want : predicted);
		commands_taken++;
		if (c.action <= frce_pkg::ACT_NEXT)
			items_sent++;
		@(negedge clk);
	endtask

	task automatic wait_rows_drained();
		cmd_ch.valid <= 1'b0;
		while (pending_rows.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES)
			@(negedge clk);
	endtask

	task automatic write_reg(input frce_pkg::cfg_index_t idx, input logic [15:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		case (idx)
			frce_pkg::CFG_FRAME_WIDTH:  fb_width = value;
			frce_pkg::CFG_FRAME_HEIGHT: fb_height = value;
			frce_pkg::CFG_ROW_PITCH:    fb_pitch = value;
			frce_pkg::CFG_PIXEL_BITS:   fb_pixel_bits = value[5:0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	function automatic frce_pkg::cmd_t random_cmd(input frce_pkg::action_t a);
		return make_cmd(a, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
			$urandom, 16'($urandom), $urandom);
	endfunction

	// One well-formed sequence most of the time: a start command (a fill's fields are
	// mostly shaped to land inside the frame), then a handful of next-row requests. The
	// rest is a lone next-row request or a spare code.
	task automatic send_sequence();
		frce_pkg::cmd_t c;
		int             pick;
		int             pulls;
		pick = $urandom_range(0, 99);
		pulls = $urandom_range(0, 8);
		c = random_cmd(frce_pkg::ACT_NEXT);
		if (pick < 6) begin
			c.action = frce_pkg::action_t'($urandom_range(ACT_SPARE_A, ACT_SPARE_C));
			pulls = 0;
		end else if (pick < 12) begin
			pulls = 0;
		end else if (pick < 22) begin
			c.action = frce_pkg::ACT_CLEAR;
		end else if (pick < 37) begin
			c.action = frce_pkg::ACT_SCROLL;
		end else if (pick < 70) begin
			c.action = frce_pkg::ACT_FILL;
			if ($urandom_range(0, 9) != 0) begin
				c.x = 16'($urandom_range(0, int'(fb_width) - 1));
				if (fb_height != 16'd0)
					c.y = 16'($urandom_range(0, int'(fb_height) - 1));
			end
			if ($urandom_range(0, 9) != 0)
				c.area_width = 16'($urandom_range(0, 8));
			if ($urandom_range(0, 9) != 0)
				c.area_height = 16'($urandom_range(0, 6));
		end else begin
			c.action = frce_pkg::ACT_BITMAP;
			if ($urandom_range(0, 9) != 0)
				c.area_height = 16'($urandom_range(0, 6));
		end
		push_command(c, 1'b0, '0);
		repeat (pulls)
			push_command(random_cmd(frce_pkg::ACT_NEXT), 1'b0, '0);
	endtask

	// A phase changes all four registers with the engine idle, runs random
	// sequences under one idling pattern and ends with a scroll left running, so
	// that the next phase's registers apply to a transfer already under way.
	task automatic run_phase(input logic [15:0] w, input logic [15:0] h,
			input logic [15:0] pitch, input logic [15:0] bits, input int idle_pct,
			input int stall_pct, input bit hold_off);
		int target;
		write_reg(frce_pkg::CFG_FRAME_WIDTH, w);
		write_reg(frce_pkg::CFG_FRAME_HEIGHT, h);
		write_reg(frce_pkg::CFG_ROW_PITCH, pitch);
		write_reg(frce_pkg::CFG_PIXEL_BITS, bits);
		cfg_we <= 1'b0;
		settings_used++;
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		target = items_sent + ITEMS_PER_PHASE;
		while (items_sent < target) begin
			send_sequence();
			// Halfway through, the sender holds off until every descriptor is in.
			if (hold_off && items_sent >= target - ITEMS_PER_PHASE / 2) begin
				wait_rows_drained();
				hold_off = 1'b0;
			end
		end
		push_command(random_cmd(frce_pkg::ACT_SCROLL), 1'b0, '0);
		push_command(random_cmd(frce_pkg::ACT_NEXT), 1'b0, '0);
		wait_rows_drained();
	endtask

	initial begin
		directed_step_t directed_steps[NUM_DIRECTED];
		frce_pkg::row_t idle_row;
		frce_pkg::cmd_t no_fields;

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = frce_pkg::CFG_FRAME_WIDTH;
		cfg_data = '0;
		cmd_ch.valid = 1'b0;
		cmd_ch.data = '0;
		row_ch.ready = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		error_count = 0;
		items_sent = 0;
		commands_taken = 0;
		rows_checked = 0;
		idle_rows_checked = 0;
		settings_used = 1;
		quiet_cycles = 0;

		// Register defaults and an empty transfer, as after reset.
		fb_width = frce_pkg::RST_FRAME_WIDTH;
		fb_height = frce_pkg::RST_FRAME_HEIGHT;
		fb_pitch = frce_pkg::RST_ROW_PITCH;
		fb_pixel_bits = frce_pkg::RST_PIXEL_BITS;
		cur_kind = frce_pkg::KIND_NONE;
		rows_remaining = '0;
		dst_ptr = '0;
		src_ptr = '0;
		src_row = '0;
		units_per_row = '0;
		unit_size = 3'd1;
		fill_pattern = '0;
		src_step = '0;

		idle_row = make_row(frce_pkg::KIND_NONE, '0, '0, '0, 3'd1, '0, 1'b1);
		no_fields = make_cmd(frce_pkg::ACT_NEXT, '0, '0, '0, '0, '0, '0, '0);

		// Directed steps on the default 640 by 480 frame of one byte per pixel.
		// A typed descriptor is queued as written; otherwise the prediction is.
		directed_steps[0] = '{no_fields, 1'b1, idle_row};
		// Full-width fill of two rows, clipped to the frame width.
		directed_steps[1] = '{make_cmd(frce_pkg::ACT_FILL, 16'd0, 16'd0, 16'hFFFF, 16'd2,
			32'hFFFF_FFFF, 16'd0, 32'd0), 1'b0, '0};
		directed_steps[2] = '{no_fields, 1'b1,
			make_row(frce_pkg::KIND_FILL, 32'd0, 32'd0, 18'd640, 3'd1, 32'hFF, 1'b0)};
		directed_steps[3] = '{no_fields, 1'b1,
			make_row(frce_pkg::KIND_FILL, 32'd640, 32'd0, 18'd640, 3'd1, 32'hFF, 1'b1)};
		directed_steps[4] = '{no_fields, 1'b1, idle_row};
		// Bottom-right pixel: both width and height clip to one.
		directed_steps[5] = '{make_cmd(frce_pkg::ACT_FILL, 16'd639, 16'd479, 16'd5, 16'd5,
			32'h1234_5678, 16'd0, 32'd0), 1'b0, '0};
		directed_steps[6] = '{no_fields, 1'b1,
			make_row(frce_pkg::KIND_FILL, 32'd307199, 32'd0, 18'd1, 3'd1, 32'h78, 1'b1)};
		// A fill whose origin is off the frame cancels the one before it.
		directed_steps[7] = '{make_cmd(frce_pkg::ACT_FILL, 16'd10, 16'd10, 16'd4, 16'd4,
			32'hA5, 16'd0, 32'd0), 1'b0, '0};
		directed_steps[8] = '{make_cmd(frce_pkg::ACT_FILL, 16'd640, 16'd0, 16'd1, 16'd1,
			32'h5A, 16'd0, 32'd0), 1'b0, '0};
		directed_steps[9] = '{no_fields, 1'b1, idle_row};
		directed_steps[10] = '{make_cmd(frce_pkg::ACT_FILL, 16'd0, 16'd480, 16'd1, 16'd1,
			32'h5A, 16'd0, 32'd0), 1'b0, '0};
		// Zero rows starts nothing.
		directed_steps[11] = '{make_cmd(frce_pkg::ACT_FILL, 16'd5, 16'd5, 16'd3, 16'd0,
			32'h77, 16'd0, 32'd0), 1'b0, '0};
		directed_steps[12] = '{no_fields, 1'b1, idle_row};
		// Bitmap at the far corner of the coordinate space, not clipped.
		directed_steps[13] = '{make_cmd(frce_pkg::ACT_BITMAP, 16'hFFFF, 16'hFFFF,
			16'hFFFF, 16'd1, 32'd0, 16'd0, 32'hFFFF_FFFF), 1'b0, '0};
		directed_steps[14] = '{no_fields, 1'b1,
			make_row(frce_pkg::KIND_MEMORY, 32'd42007935, 32'hFFFF_FFFF, 18'd65535, 3'd1,
			32'd0, 1'b1)};
		// Zero-width bitmap rows, then a scroll that replaces it mid-transfer.
		directed_steps[15] = '{make_cmd(frce_pkg::ACT_BITMAP, 16'd3, 16'd2, 16'd0, 16'd3,
			32'd0, 16'd0, 32'h0000_1000), 1'b0, '0};
		directed_steps[16] = '{no_fields, 1'b0, '0};
		directed_steps[17] = '{make_cmd(frce_pkg::ACT_SCROLL, 16'd0, 16'd0, 16'd0, 16'd0,
			32'd0, 16'hFFFF, 32'd0), 1'b0, '0};
		directed_steps[18] = '{no_fields, 1'b1,
			make_row(frce_pkg::KIND_FRAME, 32'd0, 32'd163200, 18'd640, 3'd1, 32'd0, 1'b0)};
		directed_steps[19] = '{no_fields, 1'b0, '0};
		directed_steps[20] = '{make_cmd(frce_pkg::ACT_CLEAR, 16'd0, 16'd0, 16'd0, 16'd0,
			32'hFFFF_FFFF, 16'd0, 32'd0), 1'b0, '0};
		directed_steps[21] = '{no_fields, 1'b1,
			make_row(frce_pkg::KIND_FILL, 32'd0, 32'd0, 18'd640, 3'd1, 32'd0, 1'b0)};
		// Spare codes with many fields set must leave the clear running.
		directed_steps[22] = '{make_cmd(ACT_SPARE_A, 16'hFFFF, 16'd0, 16'd1, 16'd1,
			32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF), 1'b0, '0};
		directed_steps[23] = '{make_cmd(ACT_SPARE_B, 16'd0, 16'd0, 16'd1, 16'd1,
			32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF), 1'b0, '0};
		directed_steps[24] = '{make_cmd(ACT_SPARE_C, 16'hFFFF, 16'hFFFF, 16'hFFFF,
			16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF), 1'b0, '0};
		directed_steps[25] = '{no_fields, 1'b0, '0};

		repeat (3)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int i = 0; i < NUM_DIRECTED; i++)
			push_command(directed_steps[i].c, directed_steps[i].typed, directed_steps[i].want);
		wait_rows_drained();

		// Settings cover the smallest frame and the largest, 16-bit pixels, three-byte
		// pixels, a zero height and saturated pixel sizes.
		// The pixel_bits word of the second phase carries stray upper bits.
		run_phase(16'd1, 16'd1, 16'd1, 16'd8, 0, 0, 1'b0);
		run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFE0, 65, 0, 1'b0);
		run_phase(16'd100, 16'd37, 16'd400, 16'd16, 0, 65, 1'b0);
		run_phase(16'd320, 16'd200, 16'd1280, 16'd24, 35, 35, 1'b1);
		run_phase(16'd17, 16'd0, 16'd64, 16'd63, 0, 0, 1'b0);
		run_phase(16'hFFFF, 16'd3, 16'hFFFF, 16'd40, 65, 0, 1'b0);
		run_phase(16'd9, 16'd5, 16'd8, 16'd15, 0, 65, 1'b0);
		run_phase(16'd640, 16'd480, 16'd640, 16'd8, 35, 35, 1'b0);

		if (pending_rows.size() != 0)
			report_mismatch("descriptors never delivered", 32'(pending_rows.size()), '0);

		$display("Covered %0d commands (%0d counted items) over %0d register settings.",
			commands_taken, items_sent, settings_used);
		$display("Checked %0d row descriptors, %0d of them with no transfer active.",
			rows_checked, idle_rows_checked);
		if (error_count == 0) begin
			$display("framebuffer_row_command_engine_test passed");
		end else begin
			$display("%0d mismatches", error_count);
			$display("framebuffer_row_command_engine_test failed");
		end
		$finish;
	end

endmodule

`default_nettype wire

// ----- framebuffer_row_command_engine.f -----
sv/frce_pkg.sv
sv/frce_cmd_if.sv
sv/frce_row_if.sv
sv/frce_ctrl.sv
sv/frce_dp.sv
sv/framebuffer_row_command_engine.sv
dv/framebuffer_row_command_engine_test.sv
